@@ sv/triangle_sector_weight_assert.svh @@
// assertion helpers used by triangle_sector_weight
`ifndef TRIANGLE_SECTOR_WEIGHT_ASSERT_SVH
`define TRIANGLE_SECTOR_WEIGHT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define TSW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked a fixed number of cycles later
`define TSW_ASSERT_LATER(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

// consequent checked against a past value
`define TSW_ASSERT_PAST(lbl, ante, sig, dly, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> $past(sig, dly)) \
		else $error(msg);

`endif

@@ sv/tsw_pkg.sv @@
package tsw_pkg;

	localparam int COORD_W = 16;
	localparam int ANGLE_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W = 33;
	localparam int QUO_W = 16;
	localparam int FRAC_W = 15;
	localparam int DVD_W = MAG_W + FRAC_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int LATENCY = 22;

	localparam logic [ANGLE_W:0] HALF_TURN = 17'd32768;
	localparam logic [QUO_W:0] ONE_Q15 = 17'd32768;
	localparam logic signed [COORD_W-1:0] WEIGHT_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] WEIGHT_MIN = 16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_FIRST_X = 3'd2,
		CFG_FIRST_Y = 3'd3,
		CFG_SECOND_X = 3'd4,
		CFG_SECOND_Y = 3'd5,
		CFG_FIRST_ANGLE = 3'd6,
		CFG_SECOND_ANGLE = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic [ANGLE_W-1:0] first_angle;
		logic [ANGLE_W-1:0] second_angle;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic in_sector;
	} ctl_t;

endpackage

@@ sv/triangle_sector_weight.sv @@
// channel  | ports                                  | handshake
// ---------+----------------------------------------+-------------------------------
// query    | query_x, query_y, query_angle          | start, taken when busy is low
// result   | in_sector, weight, degenerate          | done, one cycle, no back-pressure
// config   | cfg_index, cfg_data                    | cfg_we, written at the edge
//
// one query transaction per cycle; each result passes through
// 4 geometry stages, the dividend stage, 16 one-bit divider stages
// and the output register; busy never rises
// arst_n clears every valid bit and the config registers
// results cannot be stalled, so the pipeline always moves

`include "triangle_sector_weight_assert.svh"

module triangle_sector_weight (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [tsw_pkg::COORD_W-1:0] query_x,
	input  logic signed [tsw_pkg::COORD_W-1:0] query_y,
	input  logic [tsw_pkg::ANGLE_W-1:0] query_angle,
	output logic done,
	output logic in_sector,
	output logic signed [tsw_pkg::COORD_W-1:0] weight,
	output logic degenerate,
	input  logic cfg_we,
	input  logic [tsw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsw_pkg::COORD_W-1:0] cfg_data
);

	// config registers
	tsw_pkg::cfg_t cfg_q;

	// front half: differences, products, cross products, magnitudes
	tsw_pkg::ctl_t ctl_s4;
	logic [tsw_pkg::MAG_W-1:0] num_s4;
	logic [tsw_pkg::MAG_W-1:0] den_s4;

	// divider outputs
	tsw_pkg::ctl_t ctl_s21;
	logic degen_s21;
	logic ovf_s21;
	logic [tsw_pkg::QUO_W-1:0] quo_s21;

	// output register
	logic done_s22;
	logic in_sector_s22;
	logic degen_s22;
	logic signed [tsw_pkg::COORD_W-1:0] weight_s22;
	logic signed [tsw_pkg::COORD_W-1:0] weight_next;

	// fully pipelined, so a new transaction is always welcome
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tsw_pkg::CFG_CENTER_X: cfg_q.center_x <= cfg_data;
				tsw_pkg::CFG_CENTER_Y: cfg_q.center_y <= cfg_data;
				tsw_pkg::CFG_FIRST_X: cfg_q.first_x <= cfg_data;
				tsw_pkg::CFG_FIRST_Y: cfg_q.first_y <= cfg_data;
				tsw_pkg::CFG_SECOND_X: cfg_q.second_x <= cfg_data;
				tsw_pkg::CFG_SECOND_Y: cfg_q.second_y <= cfg_data;
				tsw_pkg::CFG_FIRST_ANGLE: cfg_q.first_angle <= cfg_data;
				tsw_pkg::CFG_SECOND_ANGLE: cfg_q.second_angle <= cfg_data;
				default: ;
			endcase
		end
	end

	tsw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start && !busy),
		.query_x(query_x),
		.query_y(query_y),
		.query_angle(query_angle),
		.cfg(cfg_q),
		.ctl_s4(ctl_s4),
		.num_s4(num_s4),
		.den_s4(den_s4)
	);

	tsw_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s4(ctl_s4),
		.num_s4(num_s4),
		.den_s4(den_s4),
		.ctl_s21(ctl_s21),
		.degen_s21(degen_s21),
		.ovf_s21(ovf_s21),
		.quo_s21(quo_s21)
	);

	// weight = 1 - q in q1.15, clamped at both ends
	always_comb begin
		if (degen_s21) begin
			weight_next = '0;
		end else if (ovf_s21) begin
			// ratio of 2.0 or more
			weight_next = tsw_pkg::WEIGHT_MIN;
		end else if (quo_s21 == '0) begin
			// exactly 1.0 does not fit
			weight_next = tsw_pkg::WEIGHT_MAX;
		end else begin
			weight_next = tsw_pkg::COORD_W'(tsw_pkg::ONE_Q15 - {1'b0, quo_s21});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s22 <= 1'b0;
		end else begin
			done_s22 <= ctl_s21.valid;
		end
	end

	always_ff @(posedge clk) begin
		in_sector_s22 <= ctl_s21.in_sector;
		degen_s22 <= degen_s21;
		weight_s22 <= weight_next;
	end

	assign done = done_s22;
	assign in_sector = in_sector_s22;
	assign degenerate = degen_s22;
	assign weight = weight_s22;

	// every accepted query comes out after the fixed latency
	`TSW_ASSERT_LATER(a_result_follows, start && !busy, 22, done, "query lost in pipeline")
	// no result without a query that long ago
	`TSW_ASSERT_PAST(a_no_phantom, done, start, tsw_pkg::LATENCY, "result without query")
	// a degenerate sector forces the weight to zero
	`TSW_ASSERT_NOW(a_degen_zero, done && degenerate, weight == '0, "degenerate weight not zero")

endmodule

@@ sv/tsw_front.sv @@
module tsw_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [tsw_pkg::COORD_W-1:0] query_x,
	input  logic signed [tsw_pkg::COORD_W-1:0] query_y,
	input  logic [tsw_pkg::ANGLE_W-1:0] query_angle,
	input  tsw_pkg::cfg_t cfg,
	output tsw_pkg::ctl_t ctl_s4,
	output logic [tsw_pkg::MAG_W-1:0] num_s4,
	output logic [tsw_pkg::MAG_W-1:0] den_s4
);

	// stage 1: differences and arc bounds
	logic valid_s1, valid_s2, valid_s3;
	logic signed [tsw_pkg::DIFF_W-1:0] dtx_s1, dty_s1, dbx_s1, dby_s1, ex_s1, ey_s1;
	logic [tsw_pkg::ANGLE_W-1:0] lo_s1, hi_s1, ang_s1;
	// stage 2: products
	logic signed [tsw_pkg::PROD_W-1:0] pt1_s2, pt2_s2, pb1_s2, pb2_s2;
	logic [tsw_pkg::ANGLE_W-1:0] lo_s2, hi_s2, ang_s2;
	logic wrap_s2;
	// stage 3: cross products
	logic [tsw_pkg::CROSS_W-1:0] cn_s3, cm_s3;
	logic inside_s3;

	logic [tsw_pkg::ANGLE_W-1:0] span;
	logic [tsw_pkg::CROSS_W-1:0] cn_abs, cm_abs;

	assign span = hi_s1 - lo_s1;
	assign cn_abs = cn_s3[tsw_pkg::CROSS_W-1] ? (~cn_s3 + 1'b1) : cn_s3;
	assign cm_abs = cm_s3[tsw_pkg::CROSS_W-1] ? (~cm_s3 + 1'b1) : cm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			ctl_s4 <= '0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			ctl_s4.valid <= valid_s3;
			ctl_s4.in_sector <= inside_s3;
		end
	end

	always_ff @(posedge clk) begin
		dtx_s1 <= {query_x[15], query_x} - {cfg.center_x[15], cfg.center_x};
		dty_s1 <= {query_y[15], query_y} - {cfg.center_y[15], cfg.center_y};
		dbx_s1 <= {cfg.first_x[15], cfg.first_x} - {cfg.center_x[15], cfg.center_x};
		dby_s1 <= {cfg.first_y[15], cfg.first_y} - {cfg.center_y[15], cfg.center_y};
		ex_s1 <= {cfg.second_x[15], cfg.second_x} - {cfg.first_x[15], cfg.first_x};
		ey_s1 <= {cfg.second_y[15], cfg.second_y} - {cfg.first_y[15], cfg.first_y};
		if (cfg.first_angle < cfg.second_angle) begin
			lo_s1 <= cfg.first_angle;
			hi_s1 <= cfg.second_angle;
		end else begin
			lo_s1 <= cfg.second_angle;
			hi_s1 <= cfg.first_angle;
		end
		ang_s1 <= query_angle;

		pt1_s2 <= dtx_s1 * ey_s1;
		pt2_s2 <= dty_s1 * ex_s1;
		pb1_s2 <= dbx_s1 * ey_s1;
		pb2_s2 <= dby_s1 * ex_s1;
		wrap_s2 <= {1'b0, span} > tsw_pkg::HALF_TURN;
		lo_s2 <= lo_s1;
		hi_s2 <= hi_s1;
		ang_s2 <= ang_s1;

		cn_s3 <= {pt1_s2[tsw_pkg::PROD_W-1], pt1_s2} - {pt2_s2[tsw_pkg::PROD_W-1], pt2_s2};
		cm_s3 <= {pb1_s2[tsw_pkg::PROD_W-1], pb1_s2} - {pb2_s2[tsw_pkg::PROD_W-1], pb2_s2};
		if (wrap_s2) begin
			inside_s3 <= (ang_s2 >= hi_s2) || (ang_s2 <= lo_s2);
		end else begin
			inside_s3 <= (ang_s2 >= lo_s2) && (ang_s2 <= hi_s2);
		end

		num_s4 <= cn_abs[tsw_pkg::MAG_W-1:0];
		den_s4 <= cm_abs[tsw_pkg::MAG_W-1:0];
	end

endmodule

@@ sv/tsw_div.sv @@
module tsw_div (
	input  logic clk,
	input  logic arst_n,
	input  tsw_pkg::ctl_t ctl_s4,
	input  logic [tsw_pkg::MAG_W-1:0] num_s4,
	input  logic [tsw_pkg::MAG_W-1:0] den_s4,
	output tsw_pkg::ctl_t ctl_s21,
	output logic degen_s21,
	output logic ovf_s21,
	output logic [tsw_pkg::QUO_W-1:0] quo_s21
);

	localparam int QW = tsw_pkg::QUO_W;
	localparam int MW = tsw_pkg::MAG_W;

	// index 0 is the dividend stage (s5), index k the k-th quotient bit (s5+k)
	tsw_pkg::ctl_t ctl_sn [0:QW];
	logic [MW-1:0] rem_sn [0:QW];
	logic [QW-1:0] low_sn [0:QW];
	logic [QW-1:0] quo_sn [0:QW];
	logic [MW-1:0] den_sn [0:QW];
	logic degen_sn [0:QW];
	logic ovf_sn [0:QW];

	logic [tsw_pkg::DVD_W-1:0] dividend;

	// n * 2^15 + floor(m / 2)
	assign dividend = {1'b0, num_s4, {tsw_pkg::FRAC_W{1'b0}}}
		+ {{(tsw_pkg::DVD_W-MW+1){1'b0}}, den_s4[MW-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sn[0] <= '0;
		end else begin
			ctl_sn[0] <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		rem_sn[0] <= dividend[tsw_pkg::DVD_W-1:QW];
		low_sn[0] <= dividend[QW-1:0];
		quo_sn[0] <= '0;
		den_sn[0] <= den_s4;
		degen_sn[0] <= (den_s4 == '0);
		ovf_sn[0] <= 1'b0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [MW:0] shifted;
		logic take;

		assign shifted = {rem_sn[k], low_sn[k][QW-1]};
		assign take = shifted >= {1'b0, den_sn[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sn[k+1] <= '0;
			end else begin
				ctl_sn[k+1] <= ctl_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[k+1] <= take ? MW'(shifted - {1'b0, den_sn[k]}) : shifted[MW-1:0];
			low_sn[k+1] <= {low_sn[k][QW-2:0], 1'b0};
			quo_sn[k+1] <= {quo_sn[k][QW-2:0], take};
			den_sn[k+1] <= den_sn[k];
			degen_sn[k+1] <= degen_sn[k];
			if (k == 0) begin
				// quotient of 2^16 or more saturates the weight low
				ovf_sn[k+1] <= rem_sn[k] >= den_sn[k];
			end else begin
				ovf_sn[k+1] <= ovf_sn[k];
			end
		end
	end

	assign ctl_s21 = ctl_sn[QW];
	assign degen_s21 = degen_sn[QW];
	assign ovf_s21 = ovf_sn[QW];
	assign quo_s21 = quo_sn[QW];

endmodule
